// ===== rtl/morse_code_keyer_core_macros.svh =====
// Assertion macros shared by the Morse keyer RTL.
// Used by mck_queue and mck_back; no other dependencies.
`ifndef MORSE_CODE_KEYER_CORE_MACROS_SVH
`define MORSE_CODE_KEYER_CORE_MACROS_SVH

`ifndef SYNTHESIS

// antecedent in a cycle implies consequent in the same cycle
`define MCK_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("keyer check failed: same-cycle implication");

// antecedent in a cycle implies consequent in the next cycle
`define MCK_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("keyer check failed: next-cycle implication");

`else

`define MCK_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define MCK_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== rtl/mck_pkg.sv =====
// Shared types, constants and the letter table of the Morse keyer.
// No dependencies.
`default_nettype none

package mck_pkg;

   localparam int UNIT_TICKS_WIDTH = 24;
   localparam logic [UNIT_TICKS_WIDTH-1:0] UNIT_TICKS_RESET = 24'd100000;

   localparam int QUEUE_DEPTH = 2;

   localparam logic [7:0] CHAR_SPACE   = 8'h20;
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
   localparam logic [7:0] CASE_OFFSET  = 8'h20;

   // request class decided by the front
   localparam logic [1:0] KIND_TICK   = 2'd0;
   localparam logic [1:0] KIND_LETTER = 2'd1;
   localparam logic [1:0] KIND_SPACE  = 2'd2;
   localparam logic [1:0] KIND_BAD    = 2'd3;

   typedef struct packed {
      logic [1:0] kind;
      logic [2:0] code_length;
      logic [3:0] code_pattern;   // bit i = symbol i, 1 = dash
   } entry_type;

   // length in bits 6..4, pattern (first symbol in bit 0) in bits 3..0
   function automatic logic [6:0] letter_code(input logic [4:0] index);
      logic [6:0] code;
      unique case (index)
         5'd0:    code = 7'h22;
         5'd1:    code = 7'h41;
         5'd2:    code = 7'h45;
         5'd3:    code = 7'h31;
         5'd4:    code = 7'h10;
         5'd5:    code = 7'h44;
         5'd6:    code = 7'h33;
         5'd7:    code = 7'h40;
         5'd8:    code = 7'h20;
         5'd9:    code = 7'h4E;
         5'd10:   code = 7'h35;
         5'd11:   code = 7'h42;
         5'd12:   code = 7'h23;
         5'd13:   code = 7'h21;
         5'd14:   code = 7'h37;
         5'd15:   code = 7'h46;
         5'd16:   code = 7'h4B;
         5'd17:   code = 7'h32;
         5'd18:   code = 7'h30;
         5'd19:   code = 7'h11;
         5'd20:   code = 7'h34;
         5'd21:   code = 7'h48;
         5'd22:   code = 7'h36;
         5'd23:   code = 7'h49;
         5'd24:   code = 7'h4D;
         5'd25:   code = 7'h43;
         default: code = 7'h00;
      endcase
      return code;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/morse_code_keyer_core.sv =====
// Top level of the Morse keyer: front classifier, request queue and back sequencer.
// Depends on mck_pkg, mck_front, mck_queue and mck_back.
`default_nettype none

// Morse keyer core. Each request is either a timer tick (command 0) or a character
// to send (command 1); every request yields exactly one response carrying the lamp
// state after it, the busy flag, and a rejected flag for a character refused
// because the keyer was busy or the character is not a letter or space. The block
// takes one request per clock while the queue is not full: the front folds case and
// reads the letter table in the cycle of acceptance and writes a two-entry queue,
// and the back pops one entry per clock while the response register is empty or
// being taken, updating the unit counter and symbol sequencer and loading the
// response register in the same cycle. Each response is registered after the queue,
// and the block keeps accepting while a response waits to be taken until the queue
// fills. csr_write_data sets the tick count per Morse unit (0 acts as 1); write it
// only while the keyer is idle. No init sweep after reset.
module morse_code_keyer_core
   import mck_pkg::*;
#(
   parameter int UNIT_COUNT_WIDTH = 24
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_ready,
   input  wire logic                        req_command,
   input  wire logic [7:0]                  req_char_code,
   output logic                             rsp_valid,
   input  wire logic                        rsp_ready,
   output logic                             rsp_dot_lamp,
   output logic                             rsp_dash_lamp,
   output logic                             rsp_busy_res,
   output logic                             rsp_rejected,
   input  wire logic                        csr_write_enable,
   input  wire logic [UNIT_TICKS_WIDTH-1:0] csr_write_data
);

   logic      queue_full;
   logic      push;
   entry_type push_entry;
   logic      pop;
   logic      head_valid;
   entry_type head_entry;

   mck_front u_front (
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_command   (req_command),
      .req_char_code (req_char_code),
      .queue_full    (queue_full),
      .push          (push),
      .push_entry    (push_entry)
   );

   mck_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .full       (queue_full),
      .head_valid (head_valid),
      .head_entry (head_entry)
   );

   mck_back #(
      .UNIT_COUNT_WIDTH (UNIT_COUNT_WIDTH)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .head_valid       (head_valid),
      .head_entry       (head_entry),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_dot_lamp     (rsp_dot_lamp),
      .rsp_dash_lamp    (rsp_dash_lamp),
      .rsp_busy_res     (rsp_busy_res),
      .rsp_rejected     (rsp_rejected)
   );

endmodule

`default_nettype wire

// ===== rtl/mck_front.sv =====
// Front of the keyer: takes requests, folds case and looks up the letter code.
// Depends on mck_pkg.
`default_nettype none

module mck_front
   import mck_pkg::*;
(
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic       req_command,
   input  wire logic [7:0] req_char_code,
   input  wire logic       queue_full,
   output logic            push,
   output entry_type       push_entry
);

   logic [7:0] folded;
   logic [7:0] offset;
   logic [6:0] code;

   always_comb begin
      folded = req_char_code;
      if (req_char_code >= CHAR_LOWER_A && req_char_code <= CHAR_LOWER_Z) begin
         folded = req_char_code - CASE_OFFSET;
      end
      offset = folded - CHAR_UPPER_A;
      code   = letter_code(offset[4:0]);

      push_entry.code_length  = code[6:4];
      push_entry.code_pattern = code[3:0];
      if (!req_command) begin
         push_entry.kind = KIND_TICK;
      end else if (folded == CHAR_SPACE) begin
         push_entry.kind = KIND_SPACE;
      end else if (folded >= CHAR_UPPER_A && folded <= CHAR_UPPER_Z) begin
         push_entry.kind = KIND_LETTER;
      end else begin
         push_entry.kind = KIND_BAD;
      end
   end

   assign req_ready = !queue_full;
   assign push      = req_valid && !queue_full;

endmodule

`default_nettype wire

// ===== rtl/mck_queue.sv =====
// Short queue of classified requests between the front and the back.
// Depends on mck_pkg and the keyer macro header.
`default_nettype none
`include "morse_code_keyer_core_macros.svh"

module mck_queue
   import mck_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      push,
   input  wire entry_type push_entry,
   input  wire logic      pop,
   output logic           full,
   output logic           head_valid,
   output entry_type      head_entry
);

   localparam int PTR_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int COUNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [COUNT_W-1:0] DEPTH_COUNT = COUNT_W'(QUEUE_DEPTH);
   localparam logic [PTR_W-1:0]   LAST_PTR    = PTR_W'(QUEUE_DEPTH - 1);

   entry_type          slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [COUNT_W-1:0] count_ff, count_in;

   always_comb begin
      rd_ptr_in = rd_ptr_ff;
      wr_ptr_in = wr_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + COUNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - COUNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= '0;
         wr_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   assign full       = (count_ff == DEPTH_COUNT);
   assign head_valid = (count_ff != '0);
   assign head_entry = slot_ff[rd_ptr_ff];

   `MCK_ASSERT_IMPLIES(a_no_push_when_full, clock, reset, count_ff == DEPTH_COUNT, !push)
   `MCK_ASSERT_IMPLIES(a_no_pop_when_empty, clock, reset, count_ff == '0, !pop)
   `MCK_ASSERT_NEXT(a_push_only_fills, clock, reset, push && !pop, count_ff != '0)

endmodule

`default_nettype wire

// ===== rtl/mck_back.sv =====
// Back of the keyer: symbol sequencer, unit timer and the response register.
// Depends on mck_pkg and the keyer macro header.
`default_nettype none
`include "morse_code_keyer_core_macros.svh"

module mck_back
   import mck_pkg::*;
#(
   parameter int UNIT_COUNT_WIDTH = 24
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        csr_write_enable,
   input  wire logic [UNIT_TICKS_WIDTH-1:0] csr_write_data,
   input  wire logic                        head_valid,
   input  wire entry_type                   head_entry,
   output logic                             pop,
   output logic                             rsp_valid,
   input  wire logic                        rsp_ready,
   output logic                             rsp_dot_lamp,
   output logic                             rsp_dash_lamp,
   output logic                             rsp_busy_res,
   output logic                             rsp_rejected
);

   localparam int W = UNIT_COUNT_WIDTH;
   // compare width with one spare bit so both sides always get zero extension
   localparam int CMP_W = ((W > UNIT_TICKS_WIDTH) ? W : UNIT_TICKS_WIDTH) + 1;

   localparam logic [1:0] PH_IDLE = 2'd0;
   localparam logic [1:0] PH_MARK = 2'd1;
   localparam logic [1:0] PH_GAP  = 2'd2;
   localparam logic [1:0] PH_END  = 2'd3;

   logic [UNIT_TICKS_WIDTH-1:0] unit_ticks_ff;
   logic [3:0]   code_pattern_ff, code_pattern_in;
   logic [2:0]   code_length_ff, code_length_in;
   logic [2:0]   symbol_index_ff, symbol_index_in;
   logic [1:0]   phase_ff, phase_in;
   logic [W-1:0] unit_counter_ff, unit_counter_in;
   logic [2:0]   units_left_ff, units_left_in;

   logic         rsp_valid_ff, rsp_valid_in;
   logic         dot_ff, dash_ff, busy_ff, rejected_ff;

   logic [W:0]       count_inc;
   logic [W-1:0]     count_next;
   logic [CMP_W-1:0] count_ext;
   logic [CMP_W-1:0] ticks_ext;
   logic             unit_done;
   logic [2:0]       units_dec;
   logic [2:0]       next_index;
   logic             reject;
   logic             dash_now;
   logic             idle_tick_pop;

   assign pop = head_valid && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      code_pattern_in = code_pattern_ff;
      code_length_in  = code_length_ff;
      symbol_index_in = symbol_index_ff;
      phase_in        = phase_ff;
      unit_counter_in = unit_counter_ff;
      units_left_in   = units_left_ff;
      reject          = 1'b0;

      count_inc  = {1'b0, unit_counter_ff} + (W + 1)'(1);
      count_next = count_inc[W-1:0];
      count_ext  = CMP_W'(count_next);
      ticks_ext  = CMP_W'(unit_ticks_ff);
      // zero length acts as one, and a unit longer than the counter ends on wrap
      unit_done  = (count_next == '0) || (count_ext >= ticks_ext);
      units_dec  = (units_left_ff != 3'd0) ? units_left_ff - 3'd1 : 3'd0;
      next_index = symbol_index_ff + 3'd1;

      if (pop) begin
         unique case (head_entry.kind)
            KIND_TICK: begin
               if (phase_ff != PH_IDLE) begin
                  unit_counter_in = unit_done ? '0 : count_next;
                  if (unit_done) begin
                     if (units_dec != 3'd0) begin
                        units_left_in = units_dec;
                     end else begin
                        unique case (phase_ff)
                           PH_MARK: begin
                              phase_in      = PH_GAP;
                              units_left_in = 3'd1;
                           end
                           PH_GAP: begin
                              symbol_index_in = next_index;
                              if (next_index < code_length_ff) begin
                                 phase_in      = PH_MARK;
                                 units_left_in = code_pattern_ff[next_index[1:0]] ?
                                                 3'd3 : 3'd1;
                              end else begin
                                 phase_in      = PH_END;
                                 units_left_in = 3'd3;
                              end
                           end
                           PH_END: begin
                              phase_in      = PH_IDLE;
                              units_left_in = 3'd0;
                           end
                           PH_IDLE: begin
                              phase_in = PH_IDLE;
                           end
                        endcase
                     end
                  end
               end
            end
            KIND_SPACE: begin
               if (phase_ff != PH_IDLE) begin
                  reject = 1'b1;
               end else begin
                  unit_counter_in = '0;
                  symbol_index_in = 3'd0;
                  code_pattern_in = 4'd0;
                  code_length_in  = 3'd0;
                  phase_in        = PH_END;
                  units_left_in   = 3'd7;
               end
            end
            KIND_LETTER: begin
               if (phase_ff != PH_IDLE) begin
                  reject = 1'b1;
               end else begin
                  unit_counter_in = '0;
                  symbol_index_in = 3'd0;
                  code_pattern_in = head_entry.code_pattern;
                  code_length_in  = head_entry.code_length;
                  phase_in        = PH_MARK;
                  units_left_in   = head_entry.code_pattern[0] ? 3'd3 : 3'd1;
               end
            end
            KIND_BAD: begin
               reject = 1'b1;
               if (phase_ff == PH_IDLE) begin
                  unit_counter_in = '0;
                  symbol_index_in = 3'd0;
               end
            end
         endcase
      end

      dash_now = code_pattern_in[symbol_index_in[1:0]];

      // hold a response until it is taken, load a fresh one on every pop
      rsp_valid_in = pop ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         unit_ticks_ff   <= UNIT_TICKS_RESET;
         code_pattern_ff <= '0;
         code_length_ff  <= '0;
         symbol_index_ff <= '0;
         phase_ff        <= PH_IDLE;
         unit_counter_ff <= '0;
         units_left_ff   <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            unit_ticks_ff <= csr_write_data;
         end
         code_pattern_ff <= code_pattern_in;
         code_length_ff  <= code_length_in;
         symbol_index_ff <= symbol_index_in;
         phase_ff        <= phase_in;
         unit_counter_ff <= unit_counter_in;
         units_left_ff   <= units_left_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         dot_ff      <= (phase_in == PH_MARK) && !dash_now;
         dash_ff     <= (phase_in == PH_MARK) && dash_now;
         busy_ff     <= (phase_in != PH_IDLE);
         rejected_ff <= reject;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_dot_lamp  = dot_ff;
   assign rsp_dash_lamp = dash_ff;
   assign rsp_busy_res  = busy_ff;
   assign rsp_rejected  = rejected_ff;

   assign idle_tick_pop = pop && (head_entry.kind == KIND_TICK) && (phase_ff == PH_IDLE);

   `MCK_ASSERT_IMPLIES(a_idle_no_units, clock, reset, phase_ff == PH_IDLE, units_left_ff == 3'd0)
   `MCK_ASSERT_IMPLIES(a_busy_has_units, clock, reset, phase_ff != PH_IDLE, units_left_ff != 3'd0)
   `MCK_ASSERT_IMPLIES(a_one_lamp, clock, reset, rsp_valid_ff, !(dot_ff && dash_ff))
   `MCK_ASSERT_NEXT(a_idle_tick_stays, clock, reset, idle_tick_pop, phase_ff == PH_IDLE)

endmodule

`default_nettype wire

// ===== bench/tb_top.sv =====
// Self-checking bench for the Morse keyer core: random and directed requests on a
// valid/ready channel, lamp-state prediction per request, in-order response checking.
// Depends on mck_pkg and morse_code_keyer_core.
`default_nettype none

module tb_top;
   import mck_pkg::*;

   localparam int COUNTER_WIDTH = 24;
   localparam int CYCLE_LIMIT   = 2000000;

   localparam logic CMD_TICK = 1'b0;
   localparam logic CMD_LOAD = 1'b1;

   typedef enum logic [1:0] {
      KEY_IDLE  = 2'd0,
      KEY_LIT   = 2'd1,
      KEY_DARK  = 2'd2,
      KEY_CLOSE = 2'd3
   } key_phase_type;

   typedef struct packed {
      logic       command;
      logic [7:0] char_code;
   } request_type;

   typedef struct packed {
      logic dot_lamp;
      logic dash_lamp;
      logic busy;
      logic rejected;
   } lamp_state_type;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_valid = 1'b0;
   logic                        req_ready;
   logic                        req_command = CMD_TICK;
   logic [7:0]                  req_char_code = 8'h00;
   logic                        rsp_valid;
   logic                        rsp_ready = 1'b0;
   logic                        rsp_dot_lamp;
   logic                        rsp_dash_lamp;
   logic                        rsp_busy_res;
   logic                        rsp_rejected;
   logic                        csr_write_enable = 1'b0;
   logic [UNIT_TICKS_WIDTH-1:0] csr_write_data = '0;

   morse_code_keyer_core #(
      .UNIT_COUNT_WIDTH(COUNTER_WIDTH)
   ) uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_command      (req_command),
      .req_char_code    (req_char_code),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_dot_lamp     (rsp_dot_lamp),
      .rsp_dash_lamp    (rsp_dash_lamp),
      .rsp_busy_res     (rsp_busy_res),
      .rsp_rejected     (rsp_rejected),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always #4 clock = ~clock;

   // letter codes A..Z: symbol count in bits 6..4, symbols LSB first (1 = dash)
   logic [6:0] morse_rom [0:25] = '{
      7'h22, 7'h41, 7'h45, 7'h31, 7'h10, 7'h44, 7'h33, 7'h40, 7'h20, 7'h4E,
      7'h35, 7'h42, 7'h23, 7'h21, 7'h37, 7'h46, 7'h4B, 7'h32, 7'h30, 7'h11,
      7'h34, 7'h48, 7'h36, 7'h49, 7'h4D, 7'h43
   };

   // keyer state as predicted from accepted requests
   logic [UNIT_TICKS_WIDTH-1:0] key_unit_ticks = UNIT_TICKS_RESET;
   logic [3:0]                  key_pattern = '0;
   logic [2:0]                  key_length = '0;
   logic [2:0]                  key_symbol = '0;
   key_phase_type               key_phase = KEY_IDLE;
   logic [COUNTER_WIDTH-1:0]    key_count = '0;
   logic [2:0]                  key_units = '0;

   request_type    pending_requests[$];
   lamp_state_type expected_lamps[$];
   int             queued_count = 0;
   int             fail_count = 0;
   int             rsp_count = 0;
   int             cycle_count = 0;

   function automatic void begin_mark();
      key_phase = KEY_LIT;
      key_units = key_pattern[key_symbol[1:0]] ? 3'd3 : 3'd1;
   endfunction

   function automatic lamp_state_type keyer_step(input logic cmd, input logic [7:0] code);
      lamp_state_type         res;
      logic [7:0]             folded;
      logic [COUNTER_WIDTH:0] limit;
      logic [6:0]             entry;
      logic                   dash;
      res.rejected = 1'b0;
      if (cmd == CMD_LOAD) begin
         if (key_phase != KEY_IDLE) begin
            res.rejected = 1'b1;
         end else begin
            folded = code;
            if (code >= CHAR_LOWER_A && code <= CHAR_LOWER_Z) begin
               folded = code - CASE_OFFSET;
            end
            // counter and symbol clear even when the character is refused
            key_count = '0;
            key_symbol = '0;
            if (folded == CHAR_SPACE) begin
               key_pattern = '0;
               key_length = '0;
               key_phase = KEY_CLOSE;
               key_units = 3'd7;
            end else if (folded < CHAR_UPPER_A || folded > CHAR_UPPER_Z) begin
               res.rejected = 1'b1;
            end else begin
               entry = morse_rom[folded - CHAR_UPPER_A];
               key_pattern = entry[3:0];
               key_length = entry[6:4];
               begin_mark();
            end
         end
      end else if (key_phase != KEY_IDLE) begin
         limit = (key_unit_ticks == '0) ? (COUNTER_WIDTH + 1)'(1) : {1'b0, key_unit_ticks};
         key_count = key_count + 1'b1;
         if ({1'b0, key_count} + 1 > limit || key_count == '0) begin
            key_count = '0;
            if (key_units != 3'd0) key_units = key_units - 3'd1;
            if (key_units == 3'd0) begin
               case (key_phase)
                  KEY_LIT: begin
                     key_phase = KEY_DARK;
                     key_units = 3'd1;
                  end
                  KEY_DARK: begin
                     key_symbol = key_symbol + 3'd1;
                     if (key_symbol < key_length) begin
                        begin_mark();
                     end else begin
                        key_phase = KEY_CLOSE;
                        key_units = 3'd3;
                     end
                  end
                  default: begin
                     key_phase = KEY_IDLE;
                     key_units = 3'd0;
                  end
               endcase
            end
         end
      end
      dash = key_pattern[key_symbol[1:0]];
      res.dot_lamp = (key_phase == KEY_LIT) && !dash;
      res.dash_lamp = (key_phase == KEY_LIT) && dash;
      res.busy = (key_phase != KEY_IDLE);
      return res;
   endfunction

   // ticks needed to send one character completely at the current unit length
   function automatic int ticks_for(input logic [7:0] code);
      logic [7:0] folded;
      logic [6:0] entry;
      int         units;
      int         unit_len;
      folded = code;
      if (code >= CHAR_LOWER_A && code <= CHAR_LOWER_Z) folded = code - CASE_OFFSET;
      unit_len = (key_unit_ticks == '0) ? 1 : int'(key_unit_ticks);
      units = 0;
      if (folded == CHAR_SPACE) begin
         units = 7;
      end else if (folded >= CHAR_UPPER_A && folded <= CHAR_UPPER_Z) begin
         entry = morse_rom[folded - CHAR_UPPER_A];
         units = 3;
         for (int i = 0; i < int'(entry[6:4]); i++) begin
            units += entry[i] ? 4 : 2;
         end
      end
      return units * unit_len;
   endfunction

   function automatic logic [7:0] pick_char();
      int r;
      r = $urandom_range(0, 99);
      if (r < 40) return CHAR_UPPER_A + 8'($urandom_range(0, 25));
      if (r < 75) return CHAR_LOWER_A + 8'($urandom_range(0, 25));
      if (r < 88) return CHAR_SPACE;
      return 8'($urandom_range(0, 255));
   endfunction

   task automatic push_item(input logic cmd, input logic [7:0] code);
      request_type item;
      item.command = cmd;
      item.char_code = code;
      pending_requests.push_back(item);
      queued_count++;
   endtask

   // load one character, then the given number of ticks, optionally with stray loads
   task automatic queue_char(input logic [7:0] code, input int ticks, input bit noisy);
      push_item(CMD_LOAD, code);
      for (int i = 0; i < ticks; i++) begin
         if (noisy && $urandom_range(0, 24) == 0) push_item(CMD_LOAD, pick_char());
         push_item(CMD_TICK, 8'($urandom_range(0, 255)));
      end
   endtask

   task automatic wait_drained();
      while (pending_requests.size() != 0 || req_valid || expected_lamps.size() != 0) begin
         @(posedge clock);
      end
   endtask

   // drain, then tick the keyer back to idle so the register can be rewritten
   task automatic settle_idle();
      int unit_len;
      wait_drained();
      while (key_phase != KEY_IDLE) begin
         unit_len = (key_unit_ticks == '0) ? 1 : int'(key_unit_ticks);
         repeat (4 * unit_len) push_item(CMD_TICK, 8'($urandom_range(0, 255)));
         wait_drained();
      end
      repeat (4) @(posedge clock);
   endtask

   task automatic write_unit_ticks(input logic [UNIT_TICKS_WIDTH-1:0] value);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      key_unit_ticks = value;
   endtask

   task automatic add_random_traffic(input int target);
      int         start;
      int         r;
      logic [7:0] code;
      start = queued_count;
      while (queued_count - start < target) begin
         r = $urandom_range(0, 99);
         code = pick_char();
         if (r < 75) begin
            queue_char(code, ticks_for(code) + $urandom_range(0, 2), 1'b1);
         end else if (r < 88) begin
            // cut short so the next load lands while busy
            queue_char(code, $urandom_range(0, ticks_for(code)), 1'b1);
         end else begin
            repeat ($urandom_range(1, 6)) begin
               push_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
            end
         end
      end
   endtask

   // driver: bursts of requests with random gaps
   int burst_left = 1;
   int gap_left = 0;

   always @(posedge clock) begin : request_driver
      logic        offering;
      request_type next_req;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         offering = req_valid;
         if (req_valid && req_ready) begin
            expected_lamps.push_back(keyer_step(req_command, req_char_code));
            offering = 1'b0;
         end
         if (!offering) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (pending_requests.size() != 0) begin
               next_req = pending_requests.pop_front();
               req_command <= next_req.command;
               req_char_code <= next_req.char_code;
               req_valid <= 1'b1;
               if (burst_left <= 1) begin
                  burst_left = $urandom_range(1, 30);
                  gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
               end else begin
                  burst_left--;
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor: check each response, stall the response channel on its own pattern
   int  rx_mode = 0;
   int  mode_left = 0;
   int  hold_left = 0;
   bit  long_hold_done = 1'b0;

   always @(posedge clock) begin : response_monitor
      lamp_state_type exp;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            rsp_count++;
            if (expected_lamps.size() == 0) begin
               $error("response with no request outstanding");
               fail_count++;
            end else begin
               exp = expected_lamps.pop_front();
               if (rsp_dot_lamp !== exp.dot_lamp) begin
                  $error("dot_lamp: expected %0b, got %0b", exp.dot_lamp, rsp_dot_lamp);
                  fail_count++;
               end
               if (rsp_dash_lamp !== exp.dash_lamp) begin
                  $error("dash_lamp: expected %0b, got %0b", exp.dash_lamp, rsp_dash_lamp);
                  fail_count++;
               end
               if (rsp_busy_res !== exp.busy) begin
                  $error("busy_res: expected %0b, got %0b", exp.busy, rsp_busy_res);
                  fail_count++;
               end
               if (rsp_rejected !== exp.rejected) begin
                  $error("rejected: expected %0b, got %0b", exp.rejected, rsp_rejected);
                  fail_count++;
               end
            end
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (!long_hold_done && rsp_count >= 500) begin
            // hold off long enough for the block to fill and stall its input
            long_hold_done = 1'b1;
            hold_left = 120;
            rsp_ready <= 1'b0;
         end else begin
            if (mode_left == 0) begin
               rx_mode = $urandom_range(0, 2);
               mode_left = $urandom_range(20, 200);
            end else begin
               mode_left--;
            end
            case (rx_mode)
               0:       rsp_ready <= 1'b1;
               1:       rsp_ready <= ($urandom_range(0, 3) != 0);
               default: rsp_ready <= ($urandom_range(0, 1) != 0);
            endcase
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("morse_code_keyer_core test failed");
         $finish;
      end
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // reset unit length: idle ticks and refused characters only
      repeat (3) push_item(CMD_TICK, 8'($urandom_range(0, 255)));
      push_item(CMD_LOAD, 8'h00);
      push_item(CMD_LOAD, 8'hFF);
      push_item(CMD_LOAD, CHAR_UPPER_A - 8'd1);
      push_item(CMD_LOAD, CHAR_UPPER_Z + 8'd1);
      push_item(CMD_LOAD, CHAR_LOWER_A - 8'd1);
      push_item(CMD_LOAD, CHAR_LOWER_Z + 8'd1);
      settle_idle();

      // zero unit length behaves as one tick per unit
      write_unit_ticks('0);
      push_item(CMD_LOAD, CHAR_UPPER_A);
      push_item(CMD_LOAD, "E");
      repeat (ticks_for(CHAR_UPPER_A)) push_item(CMD_TICK, 8'($urandom_range(0, 255)));
      queue_char(CHAR_UPPER_Z, ticks_for(CHAR_UPPER_Z), 1'b0);
      queue_char(CHAR_LOWER_A, ticks_for(CHAR_LOWER_A), 1'b0);
      queue_char(CHAR_LOWER_Z, ticks_for(CHAR_LOWER_Z), 1'b0);
      queue_char("y", ticks_for("y"), 1'b0);
      queue_char("Y", ticks_for("Y"), 1'b0);
      queue_char("Q", ticks_for("Q"), 1'b0);
      queue_char(CHAR_SPACE, ticks_for(CHAR_SPACE), 1'b0);
      push_item(CMD_LOAD, 8'hE1);
      push_item(CMD_LOAD, 8'h1F);
      push_item(CMD_LOAD, 8'h21);
      push_item(CMD_LOAD, 8'h7F);
      push_item(CMD_TICK, 8'hFF);
      settle_idle();

      write_unit_ticks(24'd1);
      add_random_traffic(300);
      settle_idle();
      write_unit_ticks(24'd2);
      add_random_traffic(300);
      settle_idle();
      write_unit_ticks(24'd3);
      add_random_traffic(300);
      settle_idle();
      write_unit_ticks(24'($urandom_range(4, 8)));
      add_random_traffic(300);
      settle_idle();
      write_unit_ticks('0);
      add_random_traffic(250);
      settle_idle();

      // a few characters at a long unit
      write_unit_ticks(24'($urandom_range(10, 20)));
      queue_char("E", ticks_for("E"), 1'b1);
      queue_char("n", ticks_for("n"), 1'b1);
      settle_idle();

      // longest unit: the first dash never ends, so every later load is refused
      write_unit_ticks({UNIT_TICKS_WIDTH{1'b1}});
      push_item(CMD_LOAD, "T");
      repeat (150) push_item(1'($urandom_range(0, 1)), pick_char());
      wait_drained();
      repeat (8) @(posedge clock);

      if (fail_count == 0 && expected_lamps.size() == 0) begin
         $display("morse_code_keyer_core test passed");
      end else begin
         $display("morse_code_keyer_core test failed");
      end
      $finish;
   end

endmodule

`default_nettype wire
